// ===== rtl/core/graph_edge_store_bellman_ford_unit_defines.svh =====
// Assertion macros for the graph edge store unit.
`ifndef GRAPH_EDGE_STORE_BELLMAN_FORD_UNIT_DEFINES_SVH
`define GRAPH_EDGE_STORE_BELLMAN_FORD_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define GESBF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define GESBF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gesbf_pkg.sv =====
// Package: sizes, codes, command/status types and helpers of the graph edge store.
`default_nettype none
package gesbf_pkg;

    localparam int NUM_VERTICES = 32;
    localparam int MAX_EDGES    = 256;
    localparam int WEIGHT_BITS  = 16;

    localparam int MAX_OUT   = 32;
    localparam int TRACE_LIM = (NUM_VERTICES - 1 < MAX_OUT) ? NUM_VERTICES - 1 : MAX_OUT;

    // fixed field widths
    localparam int REQ_W   = 3;
    localparam int IVID_W  = 5;
    localparam int IW_W    = 16;
    localparam int ST_W    = 3;
    localparam int OVID_W  = 5;
    localparam int DIST_W  = 24;

    // internal widths
    localparam int VID_W   = $clog2(NUM_VERTICES);
    localparam int EIDX_W  = $clog2(MAX_EDGES);
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
    localparam int SP_W    = $clog2(NUM_VERTICES + 1);
    localparam int KCNT_W  = $clog2(MAX_OUT + 1);
    localparam int TB_W    = $clog2(MAX_OUT);
    localparam int SUM_W   = ((DIST_W > WEIGHT_BITS) ? DIST_W : WEIGHT_BITS) + 2;

    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    typedef enum logic [REQ_W-1:0] {
        RQ_ADD_VTX  = 3'd0,
        RQ_REM_VTX  = 3'd1,
        RQ_ADD_EDGE = 3'd2,
        RQ_REM_EDGE = 3'd3,
        RQ_HAS_EDGE = 3'd4,
        RQ_PATH     = 3'd5,
        RQ_WALK     = 3'd6,
        RQ_CLEAR    = 3'd7
    } req_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_NO_PATH   = 3'd3,
        ST_CUT       = 3'd4
    } st_t;

    typedef struct packed {
        logic [VID_W-1:0]              src;
        logic [VID_W-1:0]              dst;
        logic signed [WEIGHT_BITS-1:0] w;
    } edge_t;

    // datapath micro-operations
    typedef enum logic [4:0] {
        DP_NOP, DP_LATCH, DP_ADD_VTX, DP_RV_START, DP_SCAN_RD, DP_RV_KEEP, DP_RV_DONE,
        DP_APPEND, DP_E_CLR, DP_E_INC, DP_SH_RD, DP_SH_WR, DP_CNT_DEC, DP_CLEAR,
        DP_BF_INIT, DP_PASS_INC, DP_DIST_RD, DP_RELAX, DP_TR_INIT, DP_TR_RD, DP_TR_PUSH,
        DP_TR_CUT, DP_PO_INIT, DP_PO_EMIT, DP_EMIT_ST, DP_WK_INIT, DP_WK_TOP, DP_WK_POP,
        DP_WK_EMIT, DP_WK_FIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        st_t    st;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        req_t req;
        logic a_ok;
        logic b_ok;
        logic pres_a;
        logic pres_b;
        logic full;
        logic scan_end;
        logic sh_end;
        logic match;
        logic pass_end;
        logic src_reached;
        logic tr_none;
        logic tr_home;
        logic tr_stop;
        logic j_zero;
        logic wk_stop;
        logic wk_found;
    } stat_t;

    typedef enum logic [4:0] {
        CS_IDLE, CS_DISPATCH, CS_STATUS, CS_RV_RD, CS_RV_EV, CS_FE_RD, CS_FE_EV,
        CS_SH_RD, CS_SH_EV, CS_BF_PASS, CS_BF_RD, CS_BF_EV1, CS_BF_EV2, CS_TR_CHK,
        CS_TR_STEP, CS_TR_EV, CS_PO, CS_WK_TOP, CS_WK_RD, CS_WK_EV, CS_WK_EMIT, CS_WK_FIN
    } ctrl_state_t;

    // wrap an input weight to a signed WEIGHT_BITS value
    function automatic logic signed [WEIGHT_BITS-1:0] wrap_weight(
        input logic signed [IW_W-1:0] raw
    );
        logic signed [31:0] x;
        x = 32'(raw);
        return x[WEIGHT_BITS-1:0];
    endfunction

    // clamp a wide sum into the distance range
    function automatic logic signed [DIST_W-1:0] sat_dist(input logic signed [SUM_W-1:0] x);
        if (x > SUM_W'(DIST_MAX))
            return DIST_MAX;
        else if (x < SUM_W'(DIST_MIN))
            return DIST_MIN;
        else
            return x[DIST_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gesbf_if.sv =====
// Request and response channel interfaces.
`default_nettype none
interface gesbf_req_if;
    import gesbf_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic [IVID_W-1:0]       vertex_a;
    logic [IVID_W-1:0]       vertex_b;
    logic signed [IW_W-1:0]  edge_weight;
    modport source (output valid, req_type, vertex_a, vertex_b, edge_weight, input ready);
    modport sink (input valid, req_type, vertex_a, vertex_b, edge_weight, output ready);
endinterface

interface gesbf_rsp_if;
    import gesbf_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [ST_W-1:0]          status;
    logic [OVID_W-1:0]        out_from;
    logic [OVID_W-1:0]        out_to;
    logic signed [DIST_W-1:0] out_weight;
    logic                     is_item;
    logic                     last;
    modport source (output valid, status, out_from, out_to, out_weight, is_item, last,
                    input ready);
    modport sink (input valid, status, out_from, out_to, out_weight, is_item, last,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/graph_edge_store_bellman_ford_unit.sv =====
// Top level of the graph edge store with shortest path and depth-first walk.
//
//  channel | dir | payload                                            | handshake
//  req     | in  | req_type, vertex_a, vertex_b, edge_weight          | valid/ready
//  rsp     | out | status, out_from, out_to, out_weight, is_item, last | valid/ready
//
// One request is taken at a time; ready is high only while the unit is idle.
// Vertex removal and edge search scan the edge table one entry at a time.
// Shortest path: n-1 relaxation passes over the edge table, with n present vertices,
// then a trace of the parent chain from the destination back to the source.
// Walk: scans the edge table from the saved position of each stack level. No clearing pass after reset.
// The output register holds a result until taken; a stalled response stalls the sequencer.
`default_nettype none
`include "graph_edge_store_bellman_ford_unit_defines.svh"
module graph_edge_store_bellman_ford_unit (
    input  logic        clk,
    input  logic        rst_n,
    gesbf_req_if.sink   req,
    gesbf_rsp_if.source rsp
);
    import gesbf_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  in_ready;

    assign req.ready = in_ready;

    // sequencer
    gesbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage and arithmetic
    gesbf_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_type    (req.req_type),
        .in_a       (req.vertex_a),
        .in_b       (req.vertex_b),
        .in_weight  (req.edge_weight),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_status (rsp.status),
        .out_from   (rsp.out_from),
        .out_to     (rsp.out_to),
        .out_weight (rsp.out_weight),
        .out_item   (rsp.is_item),
        .out_last   (rsp.last)
    );

    // checks
    `GESBF_ASSERT_NXT(a_busy_after_req, clk, rst_n, req.valid && req.ready, !req.ready,
        "request taken while previous one still running")
    `GESBF_ASSERT_IMP(a_status_zero, clk, rst_n, rsp.valid && !rsp.is_item,
        rsp.out_from == '0 && rsp.out_to == '0 && rsp.out_weight == '0 && rsp.last,
        "status-only result carries payload or is not last")
    `GESBF_ASSERT_IMP(a_cut_is_item, clk, rst_n, rsp.valid && rsp.status == ST_CUT,
        rsp.is_item, "cut status on a non-item result")

endmodule
`default_nettype wire

// ===== rtl/core/gesbf_ctrl.sv =====
// Controller state machine: sequences each request through datapath micro-operations.
`default_nettype none
module gesbf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  gesbf_pkg::stat_t stat,
    output gesbf_pkg::cmd_t  cmd
);
    import gesbf_pkg::*;

    ctrl_state_t state_reg, state_next;
    st_t         st_reg, st_next;

    // state and pending status code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        cmd.op     = DP_NOP;
        cmd.st     = st_reg;
        in_ready   = 1'b0;
        case (state_reg)
            CS_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = DP_LATCH;
                    state_next = CS_DISPATCH;
                end
            end
            CS_DISPATCH:
            begin
                state_next = CS_STATUS;
                st_next    = ST_NOT_FOUND;
                case (stat.req)
                    RQ_ADD_VTX:
                    begin
                        if (stat.a_ok)
                        begin
                            cmd.op  = DP_ADD_VTX;
                            st_next = ST_OK;
                        end
                    end
                    RQ_REM_VTX:
                    begin
                        if (stat.a_ok && stat.pres_a)
                        begin
                            cmd.op     = DP_RV_START;
                            state_next = CS_RV_RD;
                        end
                    end
                    RQ_ADD_EDGE:
                    begin
                        if (stat.a_ok && stat.b_ok)
                        begin
                            if (stat.full)
                                st_next = ST_FULL;
                            else
                            begin
                                cmd.op  = DP_APPEND;
                                st_next = ST_OK;
                            end
                        end
                    end
                    RQ_REM_EDGE, RQ_HAS_EDGE:
                    begin
                        if (stat.a_ok && stat.b_ok && stat.pres_a && stat.pres_b)
                        begin
                            cmd.op     = DP_E_CLR;
                            state_next = CS_FE_RD;
                        end
                    end
                    RQ_PATH:
                    begin
                        if (stat.a_ok && stat.b_ok)
                        begin
                            cmd.op     = DP_BF_INIT;
                            state_next = CS_BF_PASS;
                        end
                    end
                    RQ_WALK:
                    begin
                        if (stat.a_ok)
                        begin
                            cmd.op     = DP_WK_INIT;
                            state_next = CS_WK_TOP;
                        end
                    end
                    default:
                    begin
                        cmd.op  = DP_CLEAR;
                        st_next = ST_OK;
                    end
                endcase
            end
            CS_STATUS:
            begin
                if (stat.slot_free)
                begin
                    cmd.op     = DP_EMIT_ST;
                    state_next = CS_IDLE;
                end
            end
            // vertex removal: compact the table
            CS_RV_RD:
            begin
                if (stat.scan_end)
                begin
                    cmd.op     = DP_RV_DONE;
                    st_next    = ST_OK;
                    state_next = CS_STATUS;
                end
                else
                begin
                    cmd.op     = DP_SCAN_RD;
                    state_next = CS_RV_EV;
                end
            end
            CS_RV_EV:
            begin
                cmd.op     = DP_RV_KEEP;
                state_next = CS_RV_RD;
            end
            // edge search
            CS_FE_RD:
            begin
                if (stat.scan_end)
                begin
                    st_next    = ST_NOT_FOUND;
                    state_next = CS_STATUS;
                end
                else
                begin
                    cmd.op     = DP_SCAN_RD;
                    state_next = CS_FE_EV;
                end
            end
            CS_FE_EV:
            begin
                if (stat.match)
                begin
                    if (stat.req == RQ_HAS_EDGE)
                    begin
                        st_next    = ST_OK;
                        state_next = CS_STATUS;
                    end
                    else
                        state_next = CS_SH_RD;
                end
                else
                begin
                    cmd.op     = DP_E_INC;
                    state_next = CS_FE_RD;
                end
            end
            // close the gap after a removed edge
            CS_SH_RD:
            begin
                if (stat.sh_end)
                begin
                    cmd.op     = DP_CNT_DEC;
                    st_next    = ST_OK;
                    state_next = CS_STATUS;
                end
                else
                begin
                    cmd.op     = DP_SH_RD;
                    state_next = CS_SH_EV;
                end
            end
            CS_SH_EV:
            begin
                cmd.op     = DP_SH_WR;
                state_next = CS_SH_RD;
            end
            // relaxation passes
            CS_BF_PASS:
            begin
                if (stat.pass_end)
                    state_next = CS_TR_CHK;
                else
                begin
                    cmd.op     = DP_E_CLR;
                    state_next = CS_BF_RD;
                end
            end
            CS_BF_RD:
            begin
                if (stat.scan_end)
                begin
                    cmd.op     = DP_PASS_INC;
                    state_next = CS_BF_PASS;
                end
                else
                begin
                    cmd.op     = DP_SCAN_RD;
                    state_next = CS_BF_EV1;
                end
            end
            CS_BF_EV1:
            begin
                if (stat.src_reached)
                begin
                    cmd.op     = DP_DIST_RD;
                    state_next = CS_BF_EV2;
                end
                else
                begin
                    cmd.op     = DP_E_INC;
                    state_next = CS_BF_RD;
                end
            end
            CS_BF_EV2:
            begin
                cmd.op     = DP_RELAX;
                state_next = CS_BF_RD;
            end
            // parent chain trace
            CS_TR_CHK:
            begin
                if (stat.tr_none)
                begin
                    st_next    = ST_NO_PATH;
                    state_next = CS_STATUS;
                end
                else
                begin
                    cmd.op     = DP_TR_INIT;
                    state_next = CS_TR_STEP;
                end
            end
            CS_TR_STEP:
            begin
                if (stat.tr_home)
                begin
                    cmd.op     = DP_PO_INIT;
                    state_next = CS_PO;
                end
                else if (stat.tr_stop)
                begin
                    cmd.op     = DP_TR_CUT;
                    state_next = CS_PO;
                end
                else
                begin
                    cmd.op     = DP_TR_RD;
                    state_next = CS_TR_EV;
                end
            end
            CS_TR_EV:
            begin
                cmd.op     = DP_TR_PUSH;
                state_next = CS_TR_STEP;
            end
            CS_PO:
            begin
                if (stat.slot_free)
                begin
                    cmd.op = DP_PO_EMIT;
                    if (stat.j_zero)
                        state_next = CS_IDLE;
                end
            end
            // depth-first walk
            CS_WK_TOP:
            begin
                if (stat.wk_stop)
                    state_next = CS_WK_FIN;
                else
                begin
                    cmd.op     = DP_WK_TOP;
                    state_next = CS_WK_RD;
                end
            end
            CS_WK_RD:
            begin
                if (stat.scan_end)
                begin
                    cmd.op     = DP_WK_POP;
                    state_next = CS_WK_TOP;
                end
                else
                begin
                    cmd.op     = DP_SCAN_RD;
                    state_next = CS_WK_EV;
                end
            end
            CS_WK_EV:
            begin
                if (stat.wk_found)
                    state_next = CS_WK_EMIT;
                else
                begin
                    cmd.op     = DP_E_INC;
                    state_next = CS_WK_RD;
                end
            end
            CS_WK_EMIT:
            begin
                if (stat.slot_free)
                begin
                    cmd.op     = DP_WK_EMIT;
                    state_next = CS_WK_TOP;
                end
            end
            CS_WK_FIN:
            begin
                if (stat.slot_free)
                begin
                    cmd.op     = DP_WK_FIN;
                    state_next = CS_IDLE;
                end
            end
            default:
                state_next = CS_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/gesbf_dpath.sv =====
// Datapath: edge table, distance memory, graph masks, trace buffer, walk stack, output register.
`default_nettype none
module gesbf_dpath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  gesbf_pkg::cmd_t                        cmd,
    output gesbf_pkg::stat_t                       stat,
    input  logic [gesbf_pkg::REQ_W-1:0]            in_type,
    input  logic [gesbf_pkg::IVID_W-1:0]           in_a,
    input  logic [gesbf_pkg::IVID_W-1:0]           in_b,
    input  logic signed [gesbf_pkg::IW_W-1:0]      in_weight,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [gesbf_pkg::ST_W-1:0]             out_status,
    output logic [gesbf_pkg::OVID_W-1:0]           out_from,
    output logic [gesbf_pkg::OVID_W-1:0]           out_to,
    output logic signed [gesbf_pkg::DIST_W-1:0]    out_weight,
    output logic                                   out_item,
    output logic                                   out_last
);
    import gesbf_pkg::*;

    // memories
    edge_t                     edge_mem [MAX_EDGES];
    logic signed [DIST_W-1:0]  dist_mem [NUM_VERTICES];
    edge_t                     rd_reg;
    logic signed [DIST_W-1:0]  dist_s_reg, dist_d_reg;

    // small register files
    logic [VID_W-1:0]          parent_reg [NUM_VERTICES];
    logic [VID_W-1:0]          stk_v_reg  [NUM_VERTICES];
    logic [ECNT_W-1:0]         stk_nx_reg [NUM_VERTICES];
    logic [VID_W-1:0]          tb_from_reg [MAX_OUT];
    logic [VID_W-1:0]          tb_to_reg   [MAX_OUT];
    logic signed [DIST_W-1:0]  tb_w_reg    [MAX_OUT];

    // request and control registers
    req_t                          rq_reg, rq_next;
    logic [VID_W-1:0]              a_reg, a_next, b_reg, b_next;
    logic                          a_ok_reg, a_ok_next, b_ok_reg, b_ok_next;
    logic signed [WEIGHT_BITS-1:0] w_reg, w_next;
    logic [ECNT_W-1:0]             count_reg, count_next;
    logic [ECNT_W-1:0]             e_reg, e_next, wi_reg, wi_next;
    logic [NUM_VERTICES-1:0]       present_reg, present_next;
    logic [NUM_VERTICES-1:0]       hp_reg, hp_next;
    logic [NUM_VERTICES-1:0]       reached_reg, reached_next;
    logic [NUM_VERTICES-1:0]       visited_reg, visited_next;
    logic [SP_W-1:0]               pass_reg, pass_next, passes_reg, passes_next;
    logic [VID_W-1:0]              cur_reg, cur_next, par_reg, par_next, pend_reg, pend_next;
    logic [KCNT_W-1:0]             k_reg, k_next;
    logic [TB_W-1:0]               j_reg, j_next;
    logic                          cut_reg, cut_next;
    logic [SP_W-1:0]               sp_reg, sp_next;

    // output register
    logic                          ov_reg, ov_next;
    st_t                           ost_reg, ost_next;
    logic [OVID_W-1:0]             ofrom_reg, ofrom_next, oto_reg, oto_next;
    logic signed [DIST_W-1:0]      ow_reg, ow_next;
    logic                          oitem_reg, oitem_next, olast_reg, olast_next;

    // memory ports
    logic                          mem_we, mem_re;
    logic [EIDX_W-1:0]             mem_waddr, mem_raddr;
    edge_t                         mem_wdata;
    logic                          dist_we, dist_re;
    logic [VID_W-1:0]              dist_waddr, dist_ra1, dist_ra2;
    logic signed [DIST_W-1:0]      dist_wdata;
    logic                          par_we, tb_we, stk_nx_we, stk_push;

    // derived values
    logic [NUM_VERTICES-1:0]       oh_a, oh_b, oh_d;
    logic [VID_W-1:0]              top_idx, push_idx;
    logic signed [SUM_W-1:0]       relax_sum, tr_diff;
    logic                          improve;
    logic [ECNT_W:0]               e_plus1;
    logic [SP_W-1:0]               n_present;

    assign oh_a      = NUM_VERTICES'(1) << a_reg;
    assign oh_b      = NUM_VERTICES'(1) << b_reg;
    assign oh_d      = NUM_VERTICES'(1) << rd_reg.dst;
    assign top_idx   = VID_W'(sp_reg - SP_W'(1));
    assign push_idx  = VID_W'(sp_reg);
    assign relax_sum = SUM_W'(dist_s_reg) + SUM_W'(rd_reg.w);
    assign tr_diff   = SUM_W'(dist_s_reg) - SUM_W'(dist_d_reg);
    assign improve   = !reached_reg[rd_reg.dst] || (relax_sum < SUM_W'(dist_d_reg));
    assign e_plus1   = {1'b0, e_reg} + (ECNT_W+1)'(1);
    assign n_present = SP_W'($countones(present_reg));

    // status to the controller
    always_comb
    begin
        stat.slot_free   = !ov_reg || out_ready;
        stat.req         = rq_reg;
        stat.a_ok        = a_ok_reg;
        stat.b_ok        = b_ok_reg;
        stat.pres_a      = present_reg[a_reg];
        stat.pres_b      = present_reg[b_reg];
        stat.full        = count_reg >= ECNT_W'(MAX_EDGES);
        stat.scan_end    = e_reg >= count_reg;
        stat.sh_end      = e_plus1 >= {1'b0, count_reg};
        stat.match       = (rd_reg.src == a_reg) && (rd_reg.dst == b_reg);
        stat.pass_end    = pass_reg == passes_reg;
        stat.src_reached = reached_reg[rd_reg.src];
        stat.tr_none     = (a_reg == b_reg) || !hp_reg[b_reg];
        stat.tr_home     = cur_reg == a_reg;
        stat.tr_stop     = (k_reg >= KCNT_W'(TRACE_LIM)) || !hp_reg[cur_reg];
        stat.j_zero      = j_reg == '0;
        stat.wk_stop     = (sp_reg == '0) || (k_reg == KCNT_W'(MAX_OUT));
        stat.wk_found    = (rd_reg.src == stk_v_reg[top_idx]) && !visited_reg[rd_reg.dst];
    end

    // micro-operation decode
    always_comb
    begin
        rq_next = rq_reg; a_next = a_reg; b_next = b_reg;
        a_ok_next = a_ok_reg; b_ok_next = b_ok_reg; w_next = w_reg;
        count_next = count_reg; e_next = e_reg; wi_next = wi_reg;
        present_next = present_reg; hp_next = hp_reg;
        reached_next = reached_reg; visited_next = visited_reg;
        pass_next = pass_reg; passes_next = passes_reg;
        cur_next = cur_reg; par_next = par_reg; pend_next = pend_reg;
        k_next = k_reg; j_next = j_reg; cut_next = cut_reg; sp_next = sp_reg;
        ost_next = ost_reg; ofrom_next = ofrom_reg; oto_next = oto_reg;
        ow_next = ow_reg; oitem_next = oitem_reg; olast_next = olast_reg;
        ov_next = ov_reg && !out_ready;
        mem_we = 1'b0; mem_re = 1'b0;
        mem_waddr = count_reg[EIDX_W-1:0];
        mem_raddr = e_reg[EIDX_W-1:0];
        mem_wdata = rd_reg;
        dist_we = 1'b0; dist_re = 1'b0;
        dist_waddr = rd_reg.dst; dist_wdata = sat_dist(relax_sum);
        dist_ra1 = rd_reg.src; dist_ra2 = rd_reg.dst;
        par_we = 1'b0; tb_we = 1'b0; stk_nx_we = 1'b0; stk_push = 1'b0;
        case (cmd.op)
            DP_LATCH:
            begin
                rq_next   = req_t'(in_type);
                a_next    = VID_W'(in_a);
                b_next    = VID_W'(in_b);
                a_ok_next = 32'(in_a) < 32'(NUM_VERTICES);
                b_ok_next = 32'(in_b) < 32'(NUM_VERTICES);
                w_next    = wrap_weight(in_weight);
            end
            DP_ADD_VTX:
                present_next = present_reg | oh_a;
            DP_RV_START:
            begin
                present_next = present_reg & ~oh_a;
                e_next       = '0;
                wi_next      = '0;
            end
            DP_SCAN_RD:
                mem_re = 1'b1;
            DP_RV_KEEP:
            begin
                if ((rd_reg.src != a_reg) && (rd_reg.dst != a_reg))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wi_reg[EIDX_W-1:0];
                    wi_next   = wi_reg + ECNT_W'(1);
                end
                e_next = e_reg + ECNT_W'(1);
            end
            DP_RV_DONE:
                count_next = wi_reg;
            DP_APPEND:
            begin
                present_next  = present_reg | oh_a | oh_b;
                mem_we        = 1'b1;
                mem_wdata.src = a_reg;
                mem_wdata.dst = b_reg;
                mem_wdata.w   = w_reg;
                count_next    = count_reg + ECNT_W'(1);
            end
            DP_E_CLR:
                e_next = '0;
            DP_E_INC:
                e_next = e_reg + ECNT_W'(1);
            DP_SH_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = e_plus1[EIDX_W-1:0];
            end
            DP_SH_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = e_reg[EIDX_W-1:0];
                e_next    = e_reg + ECNT_W'(1);
            end
            DP_CNT_DEC:
                count_next = count_reg - ECNT_W'(1);
            DP_CLEAR:
            begin
                count_next   = '0;
                present_next = '0;
                hp_next      = '0;
                visited_next = '0;
            end
            DP_BF_INIT:
            begin
                hp_next      = '0;
                reached_next = oh_a;
                dist_we      = 1'b1;
                dist_waddr   = a_reg;
                dist_wdata   = '0;
                pass_next    = '0;
                passes_next  = (n_present == '0) ? '0 : n_present - SP_W'(1);
            end
            DP_PASS_INC:
                pass_next = pass_reg + SP_W'(1);
            DP_DIST_RD:
                dist_re = 1'b1;
            DP_RELAX:
            begin
                if (improve)
                begin
                    dist_we      = 1'b1;
                    par_we       = 1'b1;
                    hp_next      = hp_reg | oh_d;
                    reached_next = reached_reg | oh_d;
                end
                e_next = e_reg + ECNT_W'(1);
            end
            DP_TR_INIT:
            begin
                cur_next = b_reg;
                k_next   = '0;
                cut_next = 1'b0;
            end
            DP_TR_RD:
            begin
                par_next = parent_reg[cur_reg];
                dist_re  = 1'b1;
                dist_ra1 = cur_reg;
                dist_ra2 = parent_reg[cur_reg];
            end
            DP_TR_PUSH:
            begin
                tb_we    = 1'b1;
                k_next   = k_reg + KCNT_W'(1);
                cur_next = par_reg;
            end
            DP_TR_CUT:
            begin
                cut_next = 1'b1;
                j_next   = TB_W'(k_reg - KCNT_W'(1));
            end
            DP_PO_INIT:
                j_next = TB_W'(k_reg - KCNT_W'(1));
            DP_PO_EMIT:
            begin
                ov_next    = 1'b1;
                ost_next   = cut_reg ? ST_CUT : ST_OK;
                ofrom_next = OVID_W'(tb_from_reg[j_reg]);
                oto_next   = OVID_W'(tb_to_reg[j_reg]);
                ow_next    = tb_w_reg[j_reg];
                oitem_next = 1'b1;
                olast_next = j_reg == '0;
                j_next     = j_reg - TB_W'(1);
            end
            DP_EMIT_ST:
            begin
                ov_next    = 1'b1;
                ost_next   = cmd.st;
                ofrom_next = '0;
                oto_next   = '0;
                ow_next    = '0;
                oitem_next = 1'b0;
                olast_next = 1'b1;
            end
            DP_WK_INIT:
            begin
                visited_next = oh_a;
                sp_next      = SP_W'(1);
                pend_next    = a_reg;
                k_next       = KCNT_W'(1);
            end
            DP_WK_TOP:
                e_next = stk_nx_reg[top_idx];
            DP_WK_POP:
                sp_next = sp_reg - SP_W'(1);
            DP_WK_EMIT:
            begin
                ov_next      = 1'b1;
                ost_next     = ST_OK;
                ofrom_next   = OVID_W'(pend_reg);
                oto_next     = '0;
                ow_next      = '0;
                oitem_next   = 1'b1;
                olast_next   = 1'b0;
                pend_next    = rd_reg.dst;
                k_next       = k_reg + KCNT_W'(1);
                visited_next = visited_reg | oh_d;
                stk_nx_we    = 1'b1;
                if (32'(sp_reg) < NUM_VERTICES)
                begin
                    stk_push = 1'b1;
                    sp_next  = sp_reg + SP_W'(1);
                end
            end
            DP_WK_FIN:
            begin
                ov_next    = 1'b1;
                ost_next   = ST_OK;
                ofrom_next = OVID_W'(pend_reg);
                oto_next   = '0;
                ow_next    = '0;
                oitem_next = 1'b1;
                olast_next = 1'b1;
            end
            default:
            begin
                ov_next = ov_reg && !out_ready;
            end
        endcase
    end

    // control state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            present_reg <= '0;
            hp_reg      <= '0;
            visited_reg <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            present_reg <= present_next;
            hp_reg      <= hp_next;
            visited_reg <= visited_next;
            ov_reg      <= ov_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        rq_reg <= rq_next; a_reg <= a_next; b_reg <= b_next;
        a_ok_reg <= a_ok_next; b_ok_reg <= b_ok_next; w_reg <= w_next;
        e_reg <= e_next; wi_reg <= wi_next; reached_reg <= reached_next;
        pass_reg <= pass_next; passes_reg <= passes_next;
        cur_reg <= cur_next; par_reg <= par_next; pend_reg <= pend_next;
        k_reg <= k_next; j_reg <= j_next; cut_reg <= cut_next; sp_reg <= sp_next;
        ost_reg <= ost_next; ofrom_reg <= ofrom_next; oto_reg <= oto_next;
        ow_reg <= ow_next; oitem_reg <= oitem_next; olast_reg <= olast_next;
    end

    // edge table: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            edge_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_reg <= edge_mem[mem_raddr];
    end

    // distance memory: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (dist_we)
            dist_mem[dist_waddr] <= dist_wdata;
        if (dist_re)
        begin
            dist_s_reg <= dist_mem[dist_ra1];
            dist_d_reg <= dist_mem[dist_ra2];
        end
    end

    // parents, trace buffer, walk stack
    always_ff @(posedge clk)
    begin
        if (par_we)
            parent_reg[rd_reg.dst] <= rd_reg.src;
        if (tb_we)
        begin
            tb_from_reg[k_reg[TB_W-1:0]] <= par_reg;
            tb_to_reg[k_reg[TB_W-1:0]]   <= cur_reg;
            tb_w_reg[k_reg[TB_W-1:0]]    <= sat_dist(tr_diff);
        end
        if (cmd.op == DP_WK_INIT)
        begin
            stk_v_reg[0]  <= a_reg;
            stk_nx_reg[0] <= '0;
        end
        if (stk_nx_we)
            stk_nx_reg[top_idx] <= e_reg + ECNT_W'(1);
        if (stk_push)
        begin
            stk_v_reg[push_idx]  <= rd_reg.dst;
            stk_nx_reg[push_idx] <= '0;
        end
    end

    assign out_valid  = ov_reg;
    assign out_status = ost_reg;
    assign out_from   = ofrom_reg;
    assign out_to     = oto_reg;
    assign out_weight = ow_reg;
    assign out_item   = oitem_reg;
    assign out_last   = olast_reg;

endmodule
`default_nettype wire

// ===== verif/tb_graph_edge_store_bellman_ford_unit.sv =====
// Self-checking testbench for the graph edge store with shortest path and depth-first walk.
`timescale 1ns / 100ps
module tb_graph_edge_store_bellman_ford_unit;
    import gesbf_pkg::*;

    localparam int STALL_LIMIT = 100000;
    localparam int FILL_LIMIT  = 30;

    typedef struct {
        logic [ST_W-1:0]          st;
        logic [OVID_W-1:0]        from_v;
        logic [OVID_W-1:0]        to_v;
        logic signed [DIST_W-1:0] wdelta;
        logic                     item;
        logic                     last;
    } graph_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    gesbf_req_if req_ch ();
    gesbf_rsp_if rsp_ch ();

    graph_edge_store_bellman_ford_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #2 clk = ~clk;

    // shadow copy of the graph
    logic [VID_W-1:0]              edge_src [MAX_EDGES];
    logic [VID_W-1:0]              edge_dst [MAX_EDGES];
    logic signed [WEIGHT_BITS-1:0] edge_w   [MAX_EDGES];
    int                            edge_cnt;
    logic [NUM_VERTICES-1:0]       present;
    longint                        dist_of  [NUM_VERTICES];
    int                            parent_of[NUM_VERTICES];

    graph_rsp_t expected_rsp[$];

    int  mismatches  = 0;
    int  reqs_sent   = 0;
    int  rsps_seen   = 0;
    int  paths_cut   = 0;
    int  idle_cycles = 0;
    int  burst_left  = 0;
    bit  gaps_on     = 1'b0;
    int  stall_mode  = 0;
    int  pat_cnt     = 0;

    function automatic longint clamp_dist(longint x);
        if (x > longint'(DIST_MAX))
            return longint'(DIST_MAX);
        if (x < longint'(DIST_MIN))
            return longint'(DIST_MIN);
        return x;
    endfunction

    function automatic graph_rsp_t mk_rsp(st_t st, int f, int t, longint d, bit item);
        graph_rsp_t r;
        r.st = st;
        r.from_v = f[OVID_W-1:0];
        r.to_v = t[OVID_W-1:0];
        r.wdelta = d[DIST_W-1:0];
        r.item = item;
        r.last = 1'b0;
        return r;
    endfunction

    // Bellman-Ford over the shadow table, then parent trace
    task automatic predict_path(int a, int b, ref graph_rsp_t res[$]);
        logic [NUM_VERTICES-1:0] reached;
        logic [NUM_VERTICES-1:0] hp;
        int passes, s, d, cur, par, k;
        longint sum;
        int tf[MAX_OUT];
        int tt[MAX_OUT];
        longint tw[MAX_OUT];
        bit cut;
        reached = '0;
        reached[a] = 1'b1;
        hp = '0;
        cut = 1'b0;
        k = 0;
        passes = ($countones(present) > 0) ? $countones(present) - 1 : 0;
        dist_of[a] = 0;
        for (int p = 0; p < passes; p++)
        begin
            for (int e = 0; e < edge_cnt; e++)
            begin
                s = edge_src[e];
                d = edge_dst[e];
                if (!reached[s])
                    continue;
                sum = dist_of[s] + longint'(edge_w[e]);
                if (!reached[d] || sum < dist_of[d])
                begin
                    dist_of[d] = clamp_dist(sum);
                    parent_of[d] = s;
                    hp[d] = 1'b1;
                    reached[d] = 1'b1;
                end
            end
        end
        if (a == b || !hp[b])
        begin
            res = {res, mk_rsp(ST_NO_PATH, 0, 0, 0, 1'b0)};
            return;
        end
        cur = b;
        while (cur != a)
        begin
            if (k >= TRACE_LIM || !hp[cur])
            begin
                cut = 1'b1;
                break;
            end
            par = parent_of[cur];
            tf[k] = par;
            tt[k] = cur;
            tw[k] = clamp_dist(dist_of[cur] - dist_of[par]);
            k++;
            cur = par;
        end
        if (cut)
            paths_cut++;
        for (int i = k - 1; i >= 0; i--)
            res = {res, mk_rsp(cut ? ST_CUT : ST_OK, tf[i], tt[i], tw[i], 1'b1)};
    endtask

    // depth-first preorder, out-edges in table order
    task automatic predict_walk(int s, ref graph_rsp_t res[$]);
        logic [NUM_VERTICES-1:0] seen;
        int stk_v[NUM_VERTICES];
        int stk_nx[NUM_VERTICES];
        int sp, e, d;
        bit found;
        seen = '0;
        seen[s] = 1'b1;
        res = {res, mk_rsp(ST_OK, s, 0, 0, 1'b1)};
        stk_v[0] = s;
        stk_nx[0] = 0;
        sp = 1;
        while (sp > 0 && res.size() < MAX_OUT)
        begin
            e = stk_nx[sp-1];
            found = 1'b0;
            while (e < edge_cnt)
            begin
                if (edge_src[e] == stk_v[sp-1] && !seen[edge_dst[e]])
                begin
                    found = 1'b1;
                    break;
                end
                e++;
            end
            if (!found)
            begin
                sp--;
                continue;
            end
            stk_nx[sp-1] = e + 1;
            d = edge_dst[e];
            seen[d] = 1'b1;
            res = {res, mk_rsp(ST_OK, d, 0, 0, 1'b1)};
            if (sp < NUM_VERTICES)
            begin
                stk_v[sp] = d;
                stk_nx[sp] = 0;
                sp++;
            end
        end
    endtask

    // apply one request to the shadow graph and queue its responses
    task automatic predict_graph(req_t rt, int a, int b, logic signed [IW_W-1:0] w);
        graph_rsp_t res[$];
        int e, k;
        case (rt)
            RQ_ADD_VTX:
            begin
                present[a] = 1'b1;
                res = {res, mk_rsp(ST_OK, 0, 0, 0, 1'b0)};
            end
            RQ_REM_VTX:
            begin
                if (!present[a])
                    res = {res, mk_rsp(ST_NOT_FOUND, 0, 0, 0, 1'b0)};
                else
                begin
                    present[a] = 1'b0;
                    k = 0;
                    for (e = 0; e < edge_cnt; e++)
                    begin
                        if (edge_src[e] == a || edge_dst[e] == a)
                            continue;
                        edge_src[k] = edge_src[e];
                        edge_dst[k] = edge_dst[e];
                        edge_w[k] = edge_w[e];
                        k++;
                    end
                    edge_cnt = k;
                    res = {res, mk_rsp(ST_OK, 0, 0, 0, 1'b0)};
                end
            end
            RQ_ADD_EDGE:
            begin
                if (edge_cnt >= MAX_EDGES)
                    res = {res, mk_rsp(ST_FULL, 0, 0, 0, 1'b0)};
                else
                begin
                    present[a] = 1'b1;
                    present[b] = 1'b1;
                    edge_src[edge_cnt] = a[VID_W-1:0];
                    edge_dst[edge_cnt] = b[VID_W-1:0];
                    edge_w[edge_cnt] = w[WEIGHT_BITS-1:0];
                    edge_cnt++;
                    res = {res, mk_rsp(ST_OK, 0, 0, 0, 1'b0)};
                end
            end
            RQ_REM_EDGE, RQ_HAS_EDGE:
            begin
                e = edge_cnt;
                if (present[a] && present[b])
                    for (e = 0; e < edge_cnt; e++)
                        if (edge_src[e] == a && edge_dst[e] == b)
                            break;
                if (e >= edge_cnt)
                    res = {res, mk_rsp(ST_NOT_FOUND, 0, 0, 0, 1'b0)};
                else
                begin
                    if (rt == RQ_REM_EDGE)
                    begin
                        for (; e + 1 < edge_cnt; e++)
                        begin
                            edge_src[e] = edge_src[e+1];
                            edge_dst[e] = edge_dst[e+1];
                            edge_w[e] = edge_w[e+1];
                        end
                        edge_cnt--;
                    end
                    res = {res, mk_rsp(ST_OK, 0, 0, 0, 1'b0)};
                end
            end
            RQ_PATH:
                predict_path(a, b, res);
            RQ_WALK:
                predict_walk(a, res);
            default:
            begin
                edge_cnt = 0;
                present = '0;
                res = {res, mk_rsp(ST_OK, 0, 0, 0, 1'b0)};
            end
        endcase
        res[res.size()-1].last = 1'b1;
        expected_rsp = {expected_rsp, res};
    endtask

    // send one request transaction; called and returns at a falling edge
    task automatic send_req(req_t rt, int a, int b, logic signed [IW_W-1:0] w);
        if (gaps_on && burst_left == 0)
        begin
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0)
            burst_left--;
        req_ch.valid = 1'b1;
        req_ch.req_type = rt;
        req_ch.vertex_a = a[IVID_W-1:0];
        req_ch.vertex_b = b[IVID_W-1:0];
        req_ch.edge_weight = w;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_graph(rt, a, b, w);
        reqs_sent++;
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic wait_drain();
        while (expected_rsp.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        pat_cnt++;
        case (stall_mode)
            0: rsp_ch.ready = 1'b1;
            1: rsp_ch.ready = ($urandom_range(0, 3) != 0);
            default: rsp_ch.ready = ((pat_cnt % 7) < 4);
        endcase
    end

    // response checker
    always @(posedge clk)
    begin
        graph_rsp_t exp_r;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            rsps_seen++;
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: st=%0d from=%0d to=%0d w=%0d item=%0b last=%0b",
                             rsp_ch.status, rsp_ch.out_from, rsp_ch.out_to,
                             rsp_ch.out_weight, rsp_ch.is_item, rsp_ch.last);
            end
            else
            begin
                exp_r = expected_rsp.pop_front();
                if (rsp_ch.status !== exp_r.st || rsp_ch.out_from !== exp_r.from_v ||
                    rsp_ch.out_to !== exp_r.to_v || rsp_ch.out_weight !== exp_r.wdelta ||
                    rsp_ch.is_item !== exp_r.item || rsp_ch.last !== exp_r.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d from=%0d to=%0d w=%0d item=%0b last=%0b, got st=%0d from=%0d to=%0d w=%0d item=%0b last=%0b",
                                 exp_r.st, exp_r.from_v, exp_r.to_v, exp_r.wdelta, exp_r.item,
                                 exp_r.last, rsp_ch.status, rsp_ch.out_from, rsp_ch.out_to,
                                 rsp_ch.out_weight, rsp_ch.is_item, rsp_ch.last);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired with %0d responses outstanding", expected_rsp.size());
            $display("graph_edge_store_bellman_ford_unit test failed");
            $finish;
        end
    end

    // corner cases: extreme weights, every request, no path, cut path
    task automatic test_directed();
        stall_mode = 0;
        gaps_on = 1'b0;
        send_req(RQ_ADD_VTX, 31, 0, 0);
        send_req(RQ_ADD_EDGE, 0, 1, 16'sh7fff);
        send_req(RQ_ADD_EDGE, 1, 2, -16'sh8000);
        send_req(RQ_ADD_EDGE, 2, 2, 5);
        send_req(RQ_HAS_EDGE, 0, 1, 0);
        send_req(RQ_HAS_EDGE, 1, 0, 0);
        send_req(RQ_HAS_EDGE, 0, 9, 0);
        send_req(RQ_PATH, 0, 2, 0);
        send_req(RQ_PATH, 0, 0, 0);
        send_req(RQ_PATH, 2, 0, 0);
        send_req(RQ_WALK, 20, 0, 0);
        send_req(RQ_WALK, 0, 0, 0);
        // a negative loop keeps the trace from reaching the source
        send_req(RQ_ADD_EDGE, 5, 3, 1);
        send_req(RQ_ADD_EDGE, 3, 4, -5);
        send_req(RQ_ADD_EDGE, 4, 3, -5);
        send_req(RQ_PATH, 5, 4, 0);
        send_req(RQ_REM_EDGE, 3, 4, 0);
        send_req(RQ_REM_EDGE, 3, 4, 0);
        send_req(RQ_REM_VTX, 2, 0, 0);
        send_req(RQ_REM_VTX, 2, 0, 0);
        send_req(RQ_PATH, 0, 31, 0);
        send_req(RQ_CLEAR, 0, 0, 0);
        send_req(RQ_WALK, 31, 0, 0);
        wait_drain();
    endtask

    // random request mix on small graphs
    task automatic test_random(int n_items);
        int op, a, b, hi;
        logic signed [IW_W-1:0] w;
        gaps_on = 1'b1;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 40 == 0)
                stall_mode = $urandom_range(0, 2);
            if (i == n_items / 2)
                wait_drain();
            hi = ($urandom_range(0, 5) == 0) ? 31 : 7;
            a = $urandom_range(0, hi);
            b = $urandom_range(0, hi);
            w = ($urandom_range(0, 4) == 0) ? IW_W'($urandom) :
                IW_W'(int'($urandom_range(0, 120)) - 20);
            op = $urandom_range(0, 99);
            if (edge_cnt > FILL_LIMIT || op < 3)
                send_req(RQ_CLEAR, a, b, w);
            else if (op < 38)
                send_req(RQ_ADD_EDGE, a, b, w);
            else if (op < 46)
                send_req(RQ_ADD_VTX, a, b, w);
            else if (op < 54)
                send_req(RQ_REM_VTX, a, b, w);
            else if (op < 62)
                send_req(RQ_REM_EDGE, a, b, w);
            else if (op < 70)
                send_req(RQ_HAS_EDGE, a, b, w);
            else if (op < 88)
                send_req(RQ_PATH, a, b, w);
            else
                send_req(RQ_WALK, a, b, w);
        end
        wait_drain();
    endtask

    initial
    begin
        edge_cnt = 0;
        present = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = RQ_ADD_VTX;
        req_ch.vertex_a = '0;
        req_ch.vertex_b = '0;
        req_ch.edge_weight = '0;
        rsp_ch.ready = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(117);
        repeat (20) @(negedge clk);

        $display("covered %0d requests and %0d responses (%0d cut paths), %0d mismatches",
                 reqs_sent, rsps_seen, paths_cut, mismatches);
        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("graph_edge_store_bellman_ford_unit test passed");
        else
            $display("graph_edge_store_bellman_ford_unit test failed");
        $finish;
    end
endmodule
